// File: hdl/acfp_pkg.sv
// shared types, character codes and command codes for the ascii command frame parser
// no dependencies
`default_nettype none

package acfp_pkg;

   // depth of the receive buffer that the held byte count tracks
   localparam int BUFFER_DEPTH = 256;
   localparam int HELD_W       = $clog2(BUFFER_DEPTH);
   localparam logic [HELD_W-1:0] HELD_LIMIT = HELD_W'(BUFFER_DEPTH - 1);

   localparam int CHAR_W   = 8;
   localparam int NUM_KEPT = 6;
   localparam int POS_W    = 4;
   localparam int CMD_W    = 4;
   localparam int VALUE_W  = 16;
   localparam int FLAGS_W  = 10;
   localparam int RSP_W    = 32;

   localparam logic [POS_W-1:0] POS_MAX  = 4'd15;
   localparam logic [POS_W-1:0] POS_FULL = 4'(NUM_KEPT);

   localparam logic [CHAR_W-1:0] CHAR_LT = 8'h3C;   // '<'
   localparam logic [CHAR_W-1:0] CHAR_GT = 8'h3E;   // '>'
   localparam logic [CHAR_W-1:0] CHAR_W_ = 8'h57;   // 'W'
   localparam logic [CHAR_W-1:0] CHAR_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_C  = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_S  = 8'h53;
   localparam logic [CHAR_W-1:0] CHAR_H  = 8'h48;
   localparam logic [CHAR_W-1:0] CHAR_L  = 8'h4C;
   localparam logic [CHAR_W-1:0] CHAR_K  = 8'h4B;
   localparam logic [CHAR_W-1:0] CHAR_0  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_1  = 8'h31;

   // '0' weighted by 100 + 10 + 1, taken off the raw digit sum
   localparam logic [VALUE_W-1:0] VALUE_BIAS = 16'd5328;

   localparam logic [CMD_W-1:0] CMD_AIR_DIR         = 4'd0;
   localparam logic [CMD_W-1:0] CMD_AIR_SPEED       = 4'd1;
   localparam logic [CMD_W-1:0] CMD_SEAT_UPDOWN     = 4'd2;
   localparam logic [CMD_W-1:0] CMD_SEAT_RIGHTLEFT  = 4'd3;
   localparam logic [CMD_W-1:0] CMD_SIDE_UPDOWN     = 4'd4;
   localparam logic [CMD_W-1:0] CMD_SIDE_RIGHTLEFT  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_KEY_CLOSE       = 4'd6;
   localparam logic [CMD_W-1:0] CMD_KEY_FAR         = 4'd7;
   localparam logic [CMD_W-1:0] CMD_KEY_OFF         = 4'd8;
   localparam logic [CMD_W-1:0] CMD_KEY_ON          = 4'd9;
   localparam logic [CMD_W-1:0] CMD_UNRECOGNIZED    = 4'd10;

   typedef logic [NUM_KEPT-1:0][CHAR_W-1:0] acfp_chars_type;

   typedef struct packed {
      logic [FLAGS_W-1:0]        flags;
      logic signed [VALUE_W-1:0] value;
      logic [CMD_W-1:0]          command;
   } acfp_result_type;

endpackage

`default_nettype wire

// File: hdl/acfp_classify.sv
// decodes the six kept frame bytes into a command code and a three-digit value
// depends on acfp_pkg
`default_nettype none

module acfp_classify
   import acfp_pkg::*;
(
   input  wire acfp_chars_type            chars,
   input  wire logic [POS_W-1:0]          position,
   output logic [CMD_W-1:0]               command,
   output logic signed [VALUE_W-1:0]      value
);

   logic                 is_value_cmd;
   logic                 is_key_cmd;
   logic [CMD_W-1:0]     group_code;
   logic                 group_ok;
   logic [VALUE_W-1:0]   digit_sum;

   always_comb begin
      group_ok   = 1'b1;
      group_code = CMD_AIR_DIR;
      case (chars[1])
         CHAR_A:  group_code = CMD_AIR_DIR;
         CHAR_C:  group_code = CMD_SEAT_UPDOWN;
         CHAR_S:  group_code = CMD_SIDE_UPDOWN;
         default: group_ok = 1'b0;
      endcase
   end

   assign digit_sum = VALUE_W'(chars[3]) * 16'd100 + VALUE_W'(chars[4]) * 16'd10
                    + VALUE_W'(chars[5]) - VALUE_BIAS;

   assign is_value_cmd = group_ok && (chars[2] == CHAR_H || chars[2] == CHAR_L);
   assign is_key_cmd   = chars[1] == CHAR_K && chars[2] == CHAR_0 && chars[3] == CHAR_0
                      && (chars[4] == CHAR_0 || chars[4] == CHAR_1)
                      && (chars[5] == CHAR_0 || chars[5] == CHAR_1);

   always_comb begin
      command = CMD_UNRECOGNIZED;
      value   = '0;
      if (position == POS_FULL && chars[0] == CHAR_W_) begin
         if (is_value_cmd) begin
            command = group_code | CMD_W'(chars[2] == CHAR_L);
            value   = digit_sum;
         end else if (is_key_cmd) begin
            case ({chars[4][0], chars[5][0]})
               2'b01:   command = CMD_KEY_CLOSE;
               2'b00:   command = CMD_KEY_FAR;
               2'b10:   command = CMD_KEY_OFF;
               default: command = CMD_KEY_ON;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// File: hdl/acfp_out_stage.sv
// result register between the parser and the result channel
// depends on acfp_pkg
`default_nettype none

module acfp_out_stage
   import acfp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire acfp_result_type result,
   output logic                 ready,
   input  wire logic            rsp_tready,
   output logic                 rsp_tvalid,
   output acfp_result_type      rsp_result
);

   logic            valid_ff, valid_in;
   acfp_result_type data_ff;

   // space when empty or when the held beat leaves this cycle
   assign ready    = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = data_ff;

endmodule

`default_nettype wire

// File: hdl/ascii_command_frame_parser_unit.sv
// top level of the ascii command frame parser: frame tracking, buffer count, sticky flags
// depends on acfp_pkg, acfp_classify, acfp_out_stage
`default_nettype none

// Takes one received byte per beat and gives one result beat each time a '>' closes a
// frame opened by '<'. A byte is taken every clock cycle as long as the result register
// is empty or its beat is being taken; the result of a closing byte appears in the cycle
// after the byte is accepted. Frame state, the held-byte count and the sticky flags are
// updated in the accept cycle by byte compares, small adds and a constant-weight digit
// sum, so the rate is one byte per cycle while the result register can take a beat.
module ascii_command_frame_parser_unit
   import acfp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // [3:0] command, [19:4] value, [29:20] flags
);

   logic                 open_ff, open_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [HELD_W-1:0]    held_ff, held_in, held_next;
   logic [HELD_W-1:0]    start_ff, start_in, start_next;
   logic [FLAGS_W-1:0]   seen_ff, seen_in;
   acfp_chars_type       chars_ff;

   logic                 accept;
   logic                 open_hit;
   logic                 close_hit;
   logic                 open_next;
   logic [POS_W-1:0]     pos_next;
   logic                 drop_all;
   logic [CMD_W-1:0]     command;
   logic signed [VALUE_W-1:0] value;
   logic                 out_ready;
   acfp_result_type      result;
   acfp_result_type      rsp_result;

   assign accept    = req_tvalid && req_tready;
   assign open_hit  = !open_ff && req_tdata == CHAR_LT;
   assign close_hit = open_ff && req_tdata == CHAR_GT;

   acfp_classify u_classify (
      .chars    (chars_ff),
      .position (pos_ff),
      .command  (command),
      .value    (value)
   );

   always_comb begin
      open_next  = open_ff;
      pos_next   = pos_ff;
      start_next = start_ff;
      held_next  = held_ff + HELD_W'(1);
      if (open_hit) begin
         open_next  = 1'b1;
         pos_next   = '0;
         start_next = held_ff;
      end else if (close_hit) begin
         open_next = 1'b0;
         pos_next  = '0;
         held_next = start_ff;
      end else if (open_ff && pos_ff != POS_MAX) begin
         pos_next = pos_ff + POS_W'(1);
      end
   end

   // held count reaches HELD_LIMIT (buffer depth minus one): drop everything including an open frame
   assign drop_all = held_next >= HELD_LIMIT;

   always_comb begin
      open_in  = open_ff;
      pos_in   = pos_ff;
      held_in  = held_ff;
      start_in = start_ff;
      seen_in  = seen_ff;
      if (accept) begin
         open_in  = open_next && !drop_all;
         pos_in   = drop_all ? '0 : pos_next;
         held_in  = drop_all ? '0 : held_next;
         start_in = drop_all ? '0 : start_next;
         if (close_hit && command != CMD_UNRECOGNIZED) begin
            seen_in = seen_ff | (FLAGS_W'(1) << command);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         pos_ff   <= '0;
         held_ff  <= '0;
         start_ff <= '0;
         seen_ff  <= '0;
      end else begin
         open_ff  <= open_in;
         pos_ff   <= pos_in;
         held_ff  <= held_in;
         start_ff <= start_in;
         seen_ff  <= seen_in;
      end
   end

   for (genvar i = 0; i < NUM_KEPT; i++) begin : g_chars
      always_ff @(posedge clock) begin
         if (accept && open_ff && !close_hit && pos_ff == POS_W'(i)) begin
            chars_ff[i] <= req_tdata;
         end
      end
   end

   assign result.command = command;
   assign result.value   = value;
   assign result.flags   = seen_in;

   acfp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && close_hit),
      .result     (result),
      .ready      (out_ready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_result (rsp_result)
   );

   assign req_tready = out_ready;
   assign rsp_tdata  = {(RSP_W - $bits(acfp_result_type))'(0), rsp_result};

endmodule

`default_nettype wire

// File: tb/sv/tb_ascii_command_frame_parser_unit.sv
// self-checking bench for ascii_command_frame_parser_unit: byte stream in, decoded frame out
// holds its own frame decoder and result scoreboard; depends on acfp_pkg and the rtl
`default_nettype none

module tb_ascii_command_frame_parser_unit;
   import acfp_pkg::*;

   // tracks frame state like the block does and keeps the decoded commands still owed
   class frame_decode_checker;
      acfp_result_type  awaited_commands[$];
      logic [CHAR_W-1:0] kept[NUM_KEPT];
      logic [POS_W-1:0] frame_len;
      logic [FLAGS_W-1:0] seen_mask;
      bit   in_frame;
      int   held_bytes;
      int   count_at_open;
      int   errors;
      int   checked;
      int   overflows;

      function new();
         foreach (kept[i]) kept[i] = '0;
         frame_len     = '0;
         seen_mask     = '0;
         in_frame      = 1'b0;
         held_bytes    = 0;
         count_at_open = 0;
         errors        = 0;
         checked       = 0;
         overflows     = 0;
      endfunction

      function acfp_result_type decode_frame();
         acfp_result_type r;
         r = '0;
         r.command = CMD_UNRECOGNIZED;
         if (frame_len != POS_FULL || kept[0] != CHAR_W_) return r;
         if ((kept[1] == CHAR_A || kept[1] == CHAR_C || kept[1] == CHAR_S) &&
             (kept[2] == CHAR_H || kept[2] == CHAR_L)) begin
            case (kept[1])
               CHAR_A: r.command = (kept[2] == CHAR_L) ? CMD_AIR_SPEED : CMD_AIR_DIR;
               CHAR_C: r.command = (kept[2] == CHAR_L) ? CMD_SEAT_RIGHTLEFT : CMD_SEAT_UPDOWN;
               default: r.command = (kept[2] == CHAR_L) ? CMD_SIDE_RIGHTLEFT : CMD_SIDE_UPDOWN;
            endcase
            // no digit check: any byte counts with its code minus '0'
            r.value = VALUE_W'(100 * (int'(kept[3]) - int'(CHAR_0)) +
                               10 * (int'(kept[4]) - int'(CHAR_0)) +
                               (int'(kept[5]) - int'(CHAR_0)));
            return r;
         end
         if (kept[1] == CHAR_K && kept[2] == CHAR_0 && kept[3] == CHAR_0 &&
             kept[4] inside {CHAR_0, CHAR_1} && kept[5] inside {CHAR_0, CHAR_1}) begin
            case ({kept[4] == CHAR_1, kept[5] == CHAR_1})
               2'b01:   r.command = CMD_KEY_CLOSE;
               2'b00:   r.command = CMD_KEY_FAR;
               2'b10:   r.command = CMD_KEY_OFF;
               default: r.command = CMD_KEY_ON;
            endcase
         end
         return r;
      endfunction

      function void take_rx_byte(logic [7:0] rx);
         acfp_result_type res;
         if (!in_frame && rx == CHAR_LT) begin
            in_frame      = 1'b1;
            frame_len     = '0;
            count_at_open = held_bytes;
            held_bytes++;
         end else if (in_frame && rx == CHAR_GT) begin
            res = decode_frame();
            if (res.command != CMD_UNRECOGNIZED) seen_mask[res.command] = 1'b1;
            res.flags = seen_mask;
            awaited_commands.push_back(res);
            in_frame   = 1'b0;
            frame_len  = '0;
            // frame bytes leave the buffer, anything before the '<' stays
            held_bytes = count_at_open;
         end else begin
            if (in_frame) begin
               if (frame_len < NUM_KEPT) kept[frame_len] = rx;
               if (frame_len != POS_MAX) frame_len++;
            end
            held_bytes++;
         end
         if (held_bytes >= BUFFER_DEPTH - 1) begin
            held_bytes    = 0;
            count_at_open = 0;
            in_frame      = 1'b0;
            frame_len     = '0;
            overflows++;
         end
      endfunction

      function void check_response(logic [RSP_W-1:0] data);
         acfp_result_type got, want;
         got = acfp_result_type'(data[$bits(acfp_result_type)-1:0]);
         checked++;
         if (awaited_commands.size() == 0) begin
            $display("%0t: unexpected result beat: command %0d value %0d flags %b", $time,
                     got.command, got.value, got.flags);
            errors++;
            return;
         end
         want = awaited_commands.pop_front();
         if (got.command !== want.command) begin
            $display("%0t: command mismatch: expected %0d actual %0d", $time,
                     want.command, got.command);
            errors++;
         end
         if (got.value !== want.value) begin
            $display("%0t: value mismatch: expected %0d actual %0d", $time,
                     want.value, got.value);
            errors++;
         end
         if (got.flags !== want.flags) begin
            $display("%0t: flags mismatch: expected %b actual %b", $time,
                     want.flags, got.flags);
            errors++;
         end
         if (data[RSP_W-1:$bits(acfp_result_type)] !== '0) begin
            $display("%0t: padding mismatch: expected 0 actual %b", $time,
                     data[RSP_W-1:$bits(acfp_result_type)]);
            errors++;
         end
      endfunction
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = 8'h00;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   frame_decode_checker checker_h;

   int  burst_left = 0;
   bit  steady_sender = 1'b0;
   int  bytes_sent = 0;
   int  long_stalls_wanted = 0;
   int  long_stalls_done = 0;
   int  stall_left = 0;
   int  ready_mode = 0;
   int  mode_left = 0;
   int  pattern_phase = 0;

   ascii_command_frame_parser_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // beats are sampled before the edge's updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) checker_h.take_rx_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) checker_h.check_response(rsp_tdata);
      end
   end

   // result side: changing stall patterns plus long hold-offs on request
   always @(posedge clock) begin
      if (long_stalls_done != long_stalls_wanted) begin
         long_stalls_done++;
         stall_left = 400;
      end
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 300);
      end
      mode_left--;
      pattern_phase = (pattern_phase + 1) % 7;
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (ready_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= (pattern_phase < 4);
         endcase
      end
   end

   task automatic send_byte(logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady_sender ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic logic [7:0] digit_char();
      if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
      return CHAR_0 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] key_bit_char();
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
      return CHAR_0 + 8'($urandom_range(0, 1));
   endfunction

   initial begin
      logic [7:0] seq[$];
      logic [7:0] grp;
      int pick;
      int seqs;
      checker_h = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed frames
      send_text(">");                        // close with nothing open
      send_text("<WAH000>");
      send_text("<WAL999>");
      send_text("<WCH123>");
      send_text("<WCL456>");
      send_text("<WSH789>");
      send_text("<WSL050>");
      send_text("<WK0001>");
      send_text("<WK0000>");
      send_text("<WK0010>");
      send_text("<WK0011>");
      send_text("<WK0012>");
      send_text("<WX0001>");
      send_text("<WAH12>");                  // too short
      send_text("<WAH1234>");                // too long
      send_text("<>");
      send_text("<W<H123>");                 // '<' inside a frame is plain data
      send_text("<<WAH12>");
      send_text("<WSL");                     // nul digits give the lowest value
      repeat (3) send_byte(8'h00);
      send_text(">");
      send_text("<WCH");                     // all-ones digits give the highest value
      repeat (3) send_byte(8'hFF);
      send_text(">");
      send_text("<WAH1234567890ABCDEFG>");   // position counter saturates
      // buffer fills while a frame is open: frame is dropped, its '>' goes stray
      send_text("<WAH");
      repeat (250) send_byte(8'h7A);
      send_text("321>");
      send_text("<WSH321>");

      // random sequences, mostly well formed frames
      seqs = 0;
      while (bytes_sent < 2300) begin
         if (seqs % 60 == 0) steady_sender = ($urandom_range(0, 3) == 0);
         if (seqs == 120) long_stalls_wanted++;
         seqs++;
         seq.delete();
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            case ($urandom_range(0, 2))
               0:       grp = CHAR_A;
               1:       grp = CHAR_C;
               default: grp = CHAR_S;
            endcase
            seq = '{CHAR_LT, CHAR_W_, grp, ($urandom_range(0, 1) != 0) ? CHAR_H : CHAR_L,
                    digit_char(), digit_char(), digit_char(), CHAR_GT};
            if ($urandom_range(0, 9) == 0) seq[$urandom_range(1, 6)] = 8'($urandom_range(0, 255));
         end else if (pick < 75) begin
            seq = '{CHAR_LT, CHAR_W_, CHAR_K, CHAR_0, CHAR_0,
                    key_bit_char(), key_bit_char(), CHAR_GT};
            if ($urandom_range(0, 9) == 0) seq[$urandom_range(1, 6)] = 8'($urandom_range(0, 255));
         end else if (pick < 87) begin
            seq.push_back(CHAR_LT);
            repeat ($urandom_range(0, 17)) seq.push_back(8'($urandom_range(0, 255)));
            seq.push_back(CHAR_GT);
         end else if (pick < 97) begin
            repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(0, 255)));
         end else begin
            seq.push_back(CHAR_GT);
         end
         foreach (seq[i]) send_byte(seq[i]);
      end
      req_tvalid <= 1'b0;

      while (checker_h.awaited_commands.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d bytes, checked %0d frame results, %0d buffer overflows",
               bytes_sent, checker_h.checked, checker_h.overflows);
      $display("commands seen %b, one long output stall with input backpressure",
               checker_h.seen_mask);
      if (checker_h.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", checker_h.awaited_commands.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
hdl/acfp_pkg.sv
hdl/acfp_classify.sv
hdl/acfp_out_stage.sv
hdl/ascii_command_frame_parser_unit.sv
tb/sv/tb_ascii_command_frame_parser_unit.sv
